>>> rtl/spimps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master pin sequencer package
// Types, command codes and shared helpers of the SPI mode-0 pin sequencer.
// ----------------------------------------------------------------------------
package spimps_pkg;

    localparam int unsigned SCK_DELAY_W = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned BIT_IDX_W   = 3;
    localparam int unsigned CMD_W       = 2;

    localparam logic [SCK_DELAY_W-1:0] SCK_DELAY_RESET = '0;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd3;

    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_END   = 2'd3
    } op_t;

    typedef struct packed {
        logic                   cs;
        logic                   sck;
        logic                   mosi;
        logic [BYTE_W-1:0]      shift;
        logic [BIT_IDX_W-1:0]   bit_index;
        logic [SCK_DELAY_W-1:0] wait_count;
        op_t                    op_mode;
        logic                   phase_high;
    } seq_state_t;

    localparam seq_state_t SEQ_STATE_RESET = '{
        cs:         1'b1,
        sck:        1'b0,
        mosi:       1'b0,
        shift:      '0,
        bit_index:  3'd7,
        wait_count: '0,
        op_mode:    OP_IDLE,
        phase_high: 1'b0
    };

    typedef struct packed {
        logic              sck_level;
        logic              mosi_level;
        logic              cs_n_level;
        logic              ready_res;
        logic [BYTE_W-1:0] read_byte;
        logic              read_done;
        logic              rejected;
    } seq_result_t;

    function automatic logic in_last_phase(op_t op, logic ph, logic [BIT_IDX_W-1:0] bi);
        logic r;
        begin
            case (op)
                OP_END:            r = ph;
                OP_WRITE, OP_READ: r = ph && (bi == '0);
                default:           r = 1'b0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> rtl/spimps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master pin sequencer channels
// Valid/ready channels for the tick items and the pin result items.
// ----------------------------------------------------------------------------
interface spimps_in_if;
    logic                              valid;
    logic                              ready;
    logic [spimps_pkg::CMD_W-1:0]      cmd;
    logic [spimps_pkg::BYTE_W-1:0]     data_byte;
    logic                              miso_level;

    modport source (output valid, output cmd, output data_byte, output miso_level,
                    input ready);
    modport sink (input valid, input cmd, input data_byte, input miso_level,
                  output ready);
endinterface

interface spimps_out_if;
    logic                          valid;
    logic                          ready;
    logic                          sck_level;
    logic                          mosi_level;
    logic                          cs_n_level;
    logic                          ready_res;
    logic [spimps_pkg::BYTE_W-1:0] read_byte;
    logic                          read_done;
    logic                          rejected;

    modport source (output valid, output sck_level, output mosi_level, output cs_n_level,
                    output ready_res, output read_byte, output read_done,
                    output rejected, input ready);
    modport sink (input valid, input sck_level, input mosi_level, input cs_n_level,
                  input ready_res, input read_byte, input read_done, input rejected,
                  output ready);
endinterface

>>> rtl/spimps_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master pin sequencer step
// Next sequencer state and pin result for one tick item.
// ----------------------------------------------------------------------------
module spimps_step
(
    input  spimps_pkg::seq_state_t                    state,
    input  logic [spimps_pkg::CMD_W-1:0]              cmd,
    input  logic [spimps_pkg::BYTE_W-1:0]             data_byte,
    input  logic                                      miso_level,
    input  logic [spimps_pkg::SCK_DELAY_W-1:0]        sck_delay,
    output spimps_pkg::seq_state_t                    state_next,
    output spimps_pkg::seq_result_t                   result
);

    logic                                  done;
    logic                                  rej;
    logic [spimps_pkg::BYTE_W-1:0]         rbyte;
    logic [spimps_pkg::BIT_IDX_W-1:0]      bi_dec;
    logic [spimps_pkg::BYTE_W-1:0]         shift_in;

    assign bi_dec   = state.bit_index - 3'd1;
    assign shift_in = {state.shift[spimps_pkg::BYTE_W-2:0], miso_level};

    always_comb
    begin
        state_next = state;
        done       = 1'b0;
        rej        = 1'b0;
        rbyte      = '0;

        if ((state.op_mode != spimps_pkg::OP_IDLE) && (state.wait_count == '0) &&
            spimps_pkg::in_last_phase(state.op_mode, state.phase_high, state.bit_index))
        begin
            state_next.op_mode = spimps_pkg::OP_IDLE;
        end

        if (state_next.op_mode == spimps_pkg::OP_IDLE)
        begin
            case (cmd)
                spimps_pkg::CMD_WRITE:
                begin
                    state_next.op_mode    = spimps_pkg::OP_WRITE;
                    state_next.cs         = 1'b0;
                    state_next.shift      = data_byte;
                    state_next.bit_index  = 3'd7;
                    state_next.sck        = 1'b0;
                    state_next.mosi       = data_byte[spimps_pkg::BYTE_W-1];
                    state_next.phase_high = 1'b0;
                    state_next.wait_count = sck_delay;
                end
                spimps_pkg::CMD_READ:
                begin
                    state_next.op_mode    = spimps_pkg::OP_READ;
                    state_next.cs         = 1'b0;
                    state_next.shift      = '0;
                    state_next.bit_index  = 3'd7;
                    state_next.sck        = 1'b0;
                    state_next.phase_high = 1'b0;
                    state_next.wait_count = sck_delay;
                end
                spimps_pkg::CMD_END:
                begin
                    state_next.op_mode    = spimps_pkg::OP_END;
                    state_next.sck        = 1'b0;
                    state_next.phase_high = 1'b0;
                    state_next.wait_count = sck_delay;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            rej = (cmd != spimps_pkg::CMD_TICK);
            if (state.wait_count != '0)
            begin
                state_next.wait_count = state.wait_count - 16'd1;
            end
            else
            begin
                case (state_next.op_mode)
                    spimps_pkg::OP_WRITE:
                    begin
                        if (!state.phase_high)
                        begin
                            state_next.sck        = 1'b1;
                            state_next.phase_high = 1'b1;
                        end
                        else
                        begin
                            state_next.bit_index  = bi_dec;
                            state_next.sck        = 1'b0;
                            state_next.mosi       = state.shift[bi_dec];
                            state_next.phase_high = 1'b0;
                        end
                        state_next.wait_count = sck_delay;
                    end
                    spimps_pkg::OP_READ:
                    begin
                        if (!state.phase_high)
                        begin
                            state_next.sck        = 1'b1;
                            state_next.shift      = shift_in;
                            if (state.bit_index == '0)
                            begin
                                done  = 1'b1;
                                rbyte = shift_in;
                            end
                            state_next.phase_high = 1'b1;
                        end
                        else
                        begin
                            state_next.bit_index  = bi_dec;
                            state_next.sck        = 1'b0;
                            if (bi_dec == '0)
                            begin
                                state_next.mosi = 1'b0;
                            end
                            state_next.phase_high = 1'b0;
                        end
                        state_next.wait_count = sck_delay;
                    end
                    default:
                    begin
                        state_next.cs         = 1'b1;
                        state_next.phase_high = 1'b1;
                        state_next.wait_count = sck_delay;
                    end
                endcase
            end
        end

        result.sck_level  = state_next.sck;
        result.mosi_level = state_next.mosi;
        result.cs_n_level = state_next.cs;
        result.ready_res  = (state_next.op_mode == spimps_pkg::OP_IDLE) ||
                            ((state_next.wait_count == '0) &&
                             spimps_pkg::in_last_phase(state_next.op_mode,
                                                       state_next.phase_high,
                                                       state_next.bit_index));
        result.read_byte  = rbyte;
        result.read_done  = done;
        result.rejected   = rej;
    end

endmodule

>>> rtl/spi_master_pin_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master pin sequencer core
// SPI mode-0 master that turns one tick item into the CS#, SCK and MOSI levels.
// ----------------------------------------------------------------------------
// The result item of a tick is registered and appears in the cycle after the tick is accepted.
// Throughput: one item per cycle; the sequencer state and the result register
// both update in the accepting cycle, and a result held by the receiver stalls the input.
// Reset: CS# high, SCK and MOSI low, sequencer idle, SCK delay at its initial value.
module spi_master_pin_sequencer_core
#(
    parameter logic [spimps_pkg::SCK_DELAY_W-1:0] SCK_DELAY_INIT =
        spimps_pkg::SCK_DELAY_RESET
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [spimps_pkg::SCK_DELAY_W-1:0] cfg_wr_data,
    spimps_in_if.sink                          in_ch,
    spimps_out_if.source                       out_ch
);

    logic [spimps_pkg::SCK_DELAY_W-1:0]   sck_delay_reg;
    spimps_pkg::seq_state_t               state_reg;
    spimps_pkg::seq_state_t               state_next;
    spimps_pkg::seq_result_t              result_next;
    spimps_pkg::seq_result_t              result_reg;
    logic                                 out_valid_reg;
    logic                                 in_fire;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    spimps_step u_step
    (
        .state       (state_reg),
        .cmd         (in_ch.cmd),
        .data_byte   (in_ch.data_byte),
        .miso_level  (in_ch.miso_level),
        .sck_delay   (sck_delay_reg),
        .state_next  (state_next),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sck_delay_reg <= SCK_DELAY_INIT;
            state_reg     <= spimps_pkg::SEQ_STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                sck_delay_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sck_level  = result_reg.sck_level;
    assign out_ch.mosi_level = result_reg.mosi_level;
    assign out_ch.cs_n_level = result_reg.cs_n_level;
    assign out_ch.ready_res  = result_reg.ready_res;
    assign out_ch.read_byte  = result_reg.read_byte;
    assign out_ch.read_done  = result_reg.read_done;
    assign out_ch.rejected   = result_reg.rejected;

    // An idle sequencer never has a half phase delay outstanding.
    a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.op_mode == spimps_pkg::OP_IDLE) |-> (state_reg.wait_count == '0))
        else $error("idle sequencer holds a pending delay");

    // A busy tick with delay left counts the delay down by exactly one.
    a_wait_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (state_reg.op_mode != spimps_pkg::OP_IDLE) &&
         (state_reg.wait_count != '0))
        |=> (state_reg.wait_count == $past(state_reg.wait_count) - 16'd1))
        else $error("half phase delay did not count down");

    // A completed read byte is reported on the tick SCK rises.
    a_done_on_rise: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.read_done) |-> (result_reg.sck_level &&
                                                     !result_reg.cs_n_level))
        else $error("read completion without SCK high and CS# low");

endmodule

>>> tb/spi_pin_level_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI pin level check
// Watches the tick and pin channels of the SPI mode-0 pin sequencer, works out
// the pin levels that each accepted tick item must produce and compares them,
// field by field and in order, with the result items that the block returns.
// ----------------------------------------------------------------------------
module spi_pin_level_check
    import spimps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [SCK_DELAY_W-1:0] cfg_wr_data,
    spimps_in_if                   in_mon,
    spimps_out_if                  out_mon,
    output int                     fail_count,
    output int                     pending
);

    logic                   m_cs;
    logic                   m_sck;
    logic                   m_mosi;
    logic [BYTE_W-1:0]      m_shift;
    logic [BIT_IDX_W-1:0]   m_bit;
    logic [SCK_DELAY_W-1:0] m_wait;
    logic [SCK_DELAY_W-1:0] m_half;
    op_t                    m_op;
    logic                   m_high;

    seq_result_t pin_results_q[$];

    function automatic logic on_final_phase();
        if (m_op == OP_END)
            return m_high;
        if (m_op == OP_WRITE || m_op == OP_READ)
            return m_high && (m_bit == '0);
        return 1'b0;
    endfunction

    task automatic open_phase(input logic high);
        m_high = high;
        m_wait = m_half;
    endtask

    task automatic advance_sequencer(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                                     input logic miso, output seq_result_t r);
        r = '0;
        if (m_op != OP_IDLE && m_wait == '0 && on_final_phase())
            m_op = OP_IDLE;
        if (m_op == OP_IDLE)
        begin
            case (cmd)
                CMD_WRITE:
                begin
                    m_op = OP_WRITE;
                    m_cs = 1'b0;
                    m_shift = data;
                    m_bit = 3'd7;
                    m_sck = 1'b0;
                    m_mosi = data[7];
                    open_phase(1'b0);
                end
                CMD_READ:
                begin
                    m_op = OP_READ;
                    m_cs = 1'b0;
                    m_shift = '0;
                    m_bit = 3'd7;
                    m_sck = 1'b0;
                    open_phase(1'b0);
                end
                CMD_END:
                begin
                    m_op = OP_END;
                    m_sck = 1'b0;
                    open_phase(1'b0);
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            if (cmd != CMD_TICK)
                r.rejected = 1'b1;
            if (m_wait != '0)
            begin
                m_wait = m_wait - 1'b1;
            end
            else if (m_op == OP_WRITE)
            begin
                if (!m_high)
                begin
                    m_sck = 1'b1;
                    open_phase(1'b1);
                end
                else
                begin
                    m_bit = m_bit - 1'b1;
                    m_sck = 1'b0;
                    m_mosi = m_shift[m_bit];
                    open_phase(1'b0);
                end
            end
            else if (m_op == OP_READ)
            begin
                if (!m_high)
                begin
                    m_sck = 1'b1;
                    m_shift = {m_shift[BYTE_W-2:0], miso};
                    if (m_bit == '0)
                    begin
                        r.read_done = 1'b1;
                        r.read_byte = m_shift;
                    end
                    open_phase(1'b1);
                end
                else
                begin
                    m_bit = m_bit - 1'b1;
                    m_sck = 1'b0;
                    if (m_bit == '0)
                        m_mosi = 1'b0;
                    open_phase(1'b0);
                end
            end
            else
            begin
                m_cs = 1'b1;
                open_phase(1'b1);
            end
        end
        r.sck_level = m_sck;
        r.mosi_level = m_mosi;
        r.cs_n_level = m_cs;
        r.ready_res = (m_op == OP_IDLE) || (m_wait == '0 && on_final_phase());
    endtask

    task automatic compare_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        seq_result_t want;
        seq_result_t got;
        if (!rst_n)
        begin
            m_cs = 1'b1;
            m_sck = 1'b0;
            m_mosi = 1'b0;
            m_shift = '0;
            m_bit = 3'd7;
            m_wait = '0;
            m_half = SCK_DELAY_RESET;
            m_op = OP_IDLE;
            m_high = 1'b0;
            pin_results_q.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
                m_half = cfg_wr_data;
            if (in_mon.valid && in_mon.ready)
            begin
                advance_sequencer(in_mon.cmd, in_mon.data_byte, in_mon.miso_level, want);
                pin_results_q.push_back(want);
            end
            if (out_mon.valid && out_mon.ready)
            begin
                got.sck_level = out_mon.sck_level;
                got.mosi_level = out_mon.mosi_level;
                got.cs_n_level = out_mon.cs_n_level;
                got.ready_res = out_mon.ready_res;
                got.read_byte = out_mon.read_byte;
                got.read_done = out_mon.read_done;
                got.rejected = out_mon.rejected;
                if (pin_results_q.size() == 0)
                begin
                    $display("%0t: result item with none expected, got %p", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = pin_results_q.pop_front();
                    compare_field("sck_level", want.sck_level, got.sck_level);
                    compare_field("mosi_level", want.mosi_level, got.mosi_level);
                    compare_field("cs_n_level", want.cs_n_level, got.cs_n_level);
                    compare_field("ready_res", want.ready_res, got.ready_res);
                    compare_field("read_byte", want.read_byte, got.read_byte);
                    compare_field("read_done", want.read_done, got.read_done);
                    compare_field("rejected", want.rejected, got.rejected);
                end
            end
            pending = pin_results_q.size();
        end
    end

endmodule

>>> tb/spi_master_pin_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master pin sequencer core testbench
// Drives tick items with write, read and end commands through several SCK
// delay settings, with random idling on both channels and one long
// stall of the result side, and leaves the checking to the pin level check.
// ----------------------------------------------------------------------------
module spi_master_pin_sequencer_core_tb;
    import spimps_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int TAIL_CYCLES    = 10;
    localparam int LONG_DELAY     = 37;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [SCK_DELAY_W-1:0] cfg_wr_data;

    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   cur_half;
    int   hold_requests;
    int   holds_served;
    int   stall_cycles;
    logic last_ready_res;

    spimps_in_if  in_ch();
    spimps_out_if out_ch();

    spi_master_pin_sequencer_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    spi_pin_level_check pin_level_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin : result_side
        int hold_left;
        hold_left = 0;
        holds_served = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = LONG_HOLD - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_cycles <= 0;
            last_ready_res <= 1'b1;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                last_ready_res <= out_ch.ready_res;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("spi_master_pin_sequencer_core_tb: errors");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic push_tick(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] data,
                             input logic miso);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= op;
        in_ch.data_byte <= data;
        in_ch.miso_level <= miso;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic push_plain_tick(input logic [CMD_W-1:0] op);
        push_tick(op, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic settle_sequencer();
        drain_results();
        while (!last_ready_res)
        begin
            push_plain_tick(CMD_TICK);
            drain_results();
        end
    endtask

    task automatic write_sck_delay(input logic [SCK_DELAY_W-1:0] value);
        settle_sequencer();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        cur_half = int'(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_traffic(input int n_items);
        int          sent;
        int          base;
        int          gap;
        logic [CMD_W-1:0] op;
        logic [CMD_W-1:0] stray;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                op = CMD_W'($urandom_range(1, 3));
                base = ((op == CMD_END) ? 2 : 16) * (cur_half + 1);
                if ($urandom_range(0, 99) < 75)
                    gap = base - 2 + int'($urandom_range(0, 3));
                else
                    gap = int'($urandom_range(0, base));
                push_plain_tick(op);
                sent++;
                for (int i = 0; i < gap; i++)
                begin
                    stray = ($urandom_range(0, 99) < 4) ? CMD_W'($urandom_range(1, 3))
                                                        : CMD_TICK;
                    push_plain_tick(stray);
                    sent++;
                end
            end
            else
            begin
                push_plain_tick(CMD_W'($urandom_range(0, 3)));
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [BYTE_W-1:0] miso_pattern;
        miso_pattern = 8'b1011_0010;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_TICK;
        in_ch.data_byte = '0;
        in_ch.miso_level = 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 67;
        cur_half = int'(SCK_DELAY_RESET);
        hold_requests = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // End of transaction with chip select already high.
        push_tick(CMD_END, 8'h00, 1'b0);
        push_tick(CMD_TICK, 8'h00, 1'b0);
        // Write with a command arriving while busy.
        push_tick(CMD_WRITE, 8'hA5, 1'b1);
        for (int i = 1; i < 16; i++)
            push_tick((i == 5) ? CMD_END : CMD_TICK, 8'hFF, 1'b1);
        // Read back a fixed MISO pattern, then close at the earliest tick.
        push_tick(CMD_READ, 8'hFF, 1'b0);
        for (int i = 1; i < 16; i++)
            push_tick(CMD_TICK, 8'h00, miso_pattern[7 - (i / 2)]);
        push_tick(CMD_END, 8'h00, 1'b0);
        push_tick(CMD_TICK, 8'h00, 1'b0);

        write_sck_delay(16'd1);
        random_traffic(300);

        send_idle_pct = 67;
        recv_idle_pct = 38;
        write_sck_delay(16'd0);
        random_traffic(40);
        hold_requests++;
        random_traffic(260);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_sck_delay(SCK_DELAY_W'(LONG_DELAY));
        push_plain_tick(CMD_END);
        for (int i = 0; i < 2 * LONG_DELAY + 2; i++)
            push_plain_tick((i == 20) ? CMD_WRITE : CMD_TICK);

        write_sck_delay(SCK_DELAY_W'($urandom_range(2, 5)));
        random_traffic(200);

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("spi_master_pin_sequencer_core_tb: clean");
        else
            $display("spi_master_pin_sequencer_core_tb: errors");
        $finish;
    end

endmodule
